FILE: design/msa_pkg.sv
// Shared types, widths and codes for the max-distance seat allocator.
package msa_pkg;

  // Fixed field widths
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int ROOM_W   = 7;

  // Build-time default and register reset value
  localparam int                MAX_SLOTS_DEF = 64;
  localparam logic [ROOM_W-1:0] ROOM_SIZE_RST = 7'd64;

  // Request codes
  localparam logic REQ_TAKE    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_REL = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;     // latch request payload
    logic clr_wr;      // clearing pass: write zero at counter address
    logic scan_init;   // reset scan counter and best-gap tracking
    logic scan_step;   // issue one map read, fold in the previous one
    logic fin_commit;  // evaluate right end, mark chosen slot, set result
    logic rel_rd;      // read map at release index
    logic rel_commit;  // check release, free slot, set result
    logic load_out;    // move result into output register
  } msa_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing pass at last entry
    logic scan_done;   // all reads issued and folded in
    logic out_free;    // output register can take a result this cycle
    logic in_take;     // incoming request is a take
  } msa_stat_t;

endpackage

FILE: design/msa_if.sv
// Handshake channel interfaces for requests and results.
interface msa_req_if import msa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, output req_type, output slot_index, input ready);
  modport sink   (input valid, input req_type, input slot_index, output ready);
endinterface

interface msa_rsp_if import msa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   assigned_slot;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output assigned_slot, output status, input ready);
  modport sink   (input valid, input assigned_slot, input status, output ready);
endinterface

FILE: design/msa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/msa_ctrl.sv
// Controller state machine: clearing pass, take scan, release and result hand-off.
module msa_ctrl import msa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  msa_stat_t stat,
  output msa_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_FINAL = 7'b0001000,
    S_RDREL = 7'b0010000,
    S_REL   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.in_take) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end else begin
            state_nxt = S_RDREL;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.fin_commit = 1'b1;
        state_nxt      = S_DONE;
      end
      S_RDREL: begin
        cmd.rel_rd = 1'b1;
        state_nxt  = S_REL;
      end
      S_REL: begin
        cmd.rel_commit = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: design/msa_dp.sv
// Datapath: occupancy RAM, gap scan, release check and result registers.
module msa_dp import msa_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  msa_cmd_t            cmd,
  output msa_stat_t           stat,
  input  logic [ROOM_W-1:0]   room_size,
  input  logic                in_req_type,
  input  logic [SLOT_W-1:0]   in_slot_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   out_assigned_slot,
  output logic [STATUS_W-1:0] out_status
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;  // map address
  localparam int NW = $clog2(MAX_SLOTS + 1);                    // holds a count
  localparam int XW = (NW > ROOM_W) ? NW : ROOM_W;              // compare width

  // Effective room size, clamped to 1..MAX_SLOTS
  logic [XW-1:0] room_x;
  logic [NW-1:0] n;
  assign room_x = XW'(room_size);
  always_comb begin
    if (room_x == '0) begin
      n = NW'(1);
    end else if (room_x > XW'(MAX_SLOTS)) begin
      n = NW'(MAX_SLOTS);
    end else begin
      n = NW'(room_x);
    end
  end

  // Registers
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [NW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                seen_r, seen_nxt;
  logic [NW-1:0]       prev_r, prev_nxt;
  logic [NW-1:0]       best_d_r, best_d_nxt;
  logic [NW-1:0]       best_s_r, best_s_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // Map RAM ports
  logic          ram_we, ram_wdata, ram_re, ram_q;
  logic [AW-1:0] ram_waddr, ram_raddr;

  msa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Scan step terms
  logic          issue;
  logic [NW-1:0] gap_d;
  logic [NW-1:0] last;
  logic [NW-1:0] end_d;
  logic          end_win;
  logic [NW-1:0] fin_d;
  logic [NW-1:0] fin_s;
  logic          in_range;

  assign issue   = cnt_r < n;
  assign gap_d   = (rd_idx_r - prev_r) >> 1;
  assign last    = n - NW'(1);
  assign end_d   = last - prev_r;
  assign end_win = (prev_r < last) && (end_d > best_d_r);
  assign fin_d   = end_win ? end_d : best_d_r;
  assign fin_s   = end_win ? last : best_s_r;
  assign in_range = XW'(idx_r) < XW'(n);

  assign stat.clear_last = (cnt_r == NW'(MAX_SLOTS - 1));
  assign stat.scan_done  = !issue && !rd_vld_r;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.in_take    = (in_req_type == REQ_TAKE);

  // RAM access selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(cnt_r);
    ram_wdata = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = AW'(cnt_r);
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end
    if (cmd.scan_step && issue) begin
      ram_re = 1'b1;
    end
    if (cmd.rel_rd) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(idx_r);
    end
    if (cmd.fin_commit && (!seen_r || fin_d != '0)) begin
      ram_we    = 1'b1;
      ram_waddr = seen_r ? AW'(fin_s) : '0;
      ram_wdata = 1'b1;
    end
    if (cmd.rel_commit && in_range && ram_q) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(idx_r);
    end
  end

  // Scan, release and result next-state logic
  always_comb begin
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    seen_nxt       = seen_r;
    prev_nxt       = prev_r;
    best_d_nxt     = best_d_r;
    best_s_nxt     = best_s_r;
    idx_nxt        = idx_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;

    if (cmd.capture) begin
      idx_nxt = in_slot_index;
    end

    // clearing pass walks every entry, then rewinds
    if (cmd.clr_wr) begin
      cnt_nxt = stat.clear_last ? '0 : cnt_r + NW'(1);
    end

    if (cmd.scan_init) begin
      cnt_nxt    = '0;
      rd_vld_nxt = 1'b0;
      seen_nxt   = 1'b0;
      prev_nxt   = '0;
      best_d_nxt = '0;
      best_s_nxt = '0;
    end

    // one read issued per cycle; its data folds in during the following cycle
    if (cmd.scan_step) begin
      rd_vld_nxt = issue;
      rd_idx_nxt = cnt_r;
      if (issue) begin
        cnt_nxt = cnt_r + NW'(1);
      end
      if (rd_vld_r && ram_q) begin
        if (!seen_r) begin
          if (rd_idx_r != '0) begin
            best_d_nxt = rd_idx_r;
            best_s_nxt = '0;
          end
          seen_nxt = 1'b1;
        end else if (rd_idx_r > prev_r + NW'(1)) begin
          if (gap_d > best_d_r) begin
            best_d_nxt = gap_d;
            best_s_nxt = prev_r + gap_d;
          end
        end
        prev_nxt = rd_idx_r;
      end
    end

    // right end and final pick; empty row takes slot 0
    if (cmd.fin_commit) begin
      if (!seen_r) begin
        res_slot_nxt   = '0;
        res_status_nxt = STATUS_OK;
      end else if (fin_d == '0) begin
        res_slot_nxt   = '0;
        res_status_nxt = STATUS_FULL;
      end else begin
        res_slot_nxt   = SLOT_W'(fin_s);
        res_status_nxt = STATUS_OK;
      end
    end

    if (cmd.rel_commit) begin
      res_slot_nxt   = idx_r;
      res_status_nxt = (in_range && ram_q) ? STATUS_OK : STATUS_BAD_REL;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt  = 1'b1;
      out_slot_nxt   = res_slot_r;
      out_status_nxt = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    seen_r       <= seen_nxt;
    prev_r       <= prev_nxt;
    best_d_r     <= best_d_nxt;
    best_s_r     <= best_s_nxt;
    idx_r        <= idx_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_assigned_slot = out_slot_r;
  assign out_status        = out_status_r;

endmodule

FILE: design/max_distance_seat_allocator.sv
// Max-distance seat allocator top level: APB register, controller and datapath.
// Keeps an occupancy map of MAX_SLOTS slots in a one-bit RAM. A take request
// scans the map one slot per cycle over the effective room size n (room_size
// clamped to 1..MAX_SLOTS), then picks the free slot farthest from its nearest
// occupied neighbor (lowest index on ties) and marks it. The single RAM read
// port sets the pace: after the scan the controller passes S_FINAL, then holds
// the result in S_DONE until the output register is free. A release reads the
// slot in S_RDREL and frees it in S_REL, then also passes S_DONE. One request
// is in flight at a time; the result sits in an output register, so it may
// wait for the sink while the next request is taken. After reset a clearing
// pass writes every map entry, during which no request is accepted; register
// writes are accepted at any time. Status 1 means the row is full, status 2 a
// release of a free or out-of-range slot.
module max_distance_seat_allocator import msa_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  msa_req_if.sink     in_req,
  msa_rsp_if.source   out_rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ROOM_W-1:0] room_size_r, room_size_nxt;
  logic              reg_sel;
  msa_cmd_t          cmd;
  msa_stat_t         stat;

  // Register 0 at byte address 0; address 4 is unmapped
  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;

  always_comb begin
    room_size_nxt = room_size_r;
    if (psel && penable && pwrite && reg_sel) begin
      room_size_nxt = pwdata[ROOM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_size_r <= ROOM_SIZE_RST;
    end else begin
      room_size_r <= room_size_nxt;
    end
  end

  assign prdata = reg_sel ? {{(32-ROOM_W){1'b0}}, room_size_r} : '0;

  msa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msa_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .room_size         (room_size_r),
    .in_req_type       (in_req.req_type),
    .in_slot_index     (in_req.slot_index),
    .out_valid         (out_rsp.valid),
    .out_ready         (out_rsp.ready),
    .out_assigned_slot (out_rsp.assigned_slot),
    .out_status        (out_rsp.status)
  );

endmodule

FILE: design/msa_chk.sv
// Port-level assertions for the seat allocator, bound to the top level.
module msa_chk import msa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SLOT_W-1:0]   out_assigned_slot,
  input logic [STATUS_W-1:0] out_status
);

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_assigned_slot) && $stable(out_status))
    else $error("result payload changed while stalled");

  // One request in flight: no transaction right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while one is in flight");

  // Full row reports slot 0, and status is never the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_BAD_REL ||
                   (out_status == STATUS_FULL && out_assigned_slot == '0)))
    else $error("bad result status or full-row slot");

endmodule

bind max_distance_seat_allocator msa_chk u_msa_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_assigned_slot (out_rsp.assigned_slot),
  .out_status        (out_rsp.status)
);

FILE: dv/tb_top.sv
// Self-checking testbench for the max-distance seat allocator.
`timescale 1ns / 100ps

module tb_top;
  import msa_pkg::*;

  localparam int SLOTS       = MAX_SLOTS_DEF;
  localparam int IDLE_PCT    = 14;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] ROOM_SIZE_ADDR = 3'd0;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } seat_result_t;

  logic clk = 1'b0;
  logic rst_n;

  // APB configuration port
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  msa_req_if req_ch ();
  msa_rsp_if rsp_ch ();

  max_distance_seat_allocator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Shadow of the occupancy map and the room_size register
  bit               seat_taken [SLOTS];
  logic [ROOM_W-1:0] room_shadow;

  seat_result_t pending_results [$];
  int  errors;
  int  mismatches;
  int  cycle_count;
  int  n_take;
  int  n_release;
  int  n_full_seen;
  int  n_bad_seen;
  int  n_results;
  int  n_rooms;
  bit  calm;

  // Effective room size: register clamped to 1..SLOTS
  function automatic int room_slots();
    int n;
    n = int'(room_shadow);
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  // Predict the result of one request and update the shadow map
  function automatic seat_result_t predict_seat(logic rt, logic [SLOT_W-1:0] idx);
    seat_result_t r;
    int n, best_d, best_s, prev, d;
    bit seen;
    n = room_slots();
    r.slot = '0;
    r.status = STATUS_OK;
    if (rt == REQ_TAKE) begin
      best_d = 0;
      best_s = 0;
      prev = 0;
      seen = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (seat_taken[i]) begin
          if (!seen) begin
            if (i > 0) begin
              best_d = i;
              best_s = 0;
            end
            seen = 1'b1;
          end else if (i > prev + 1) begin
            d = (i - prev) / 2;
            if (d > best_d) begin
              best_d = d;
              best_s = prev + d;
            end
          end
          prev = i;
        end
      end
      if (!seen) begin
        seat_taken[0] = 1'b1;
      end else begin
        if (prev < n - 1) begin
          d = n - 1 - prev;
          if (d > best_d) begin
            best_d = d;
            best_s = n - 1;
          end
        end
        if (best_d == 0) begin
          r.status = STATUS_FULL;
        end else begin
          r.slot = best_s[SLOT_W-1:0];
          seat_taken[best_s] = 1'b1;
        end
      end
    end else begin
      r.slot = idx;
      if (int'(idx) < n && seat_taken[idx]) seat_taken[idx] = 1'b0;
      else r.status = STATUS_BAD_REL;
    end
    return r;
  endfunction

  // Mismatch reporting: first few printed, the rest counted
  function automatic void report_mismatch(string what, longint unsigned exp_v,
                                          longint unsigned act_v);
    errors++;
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Result checker: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    seat_result_t exp_r;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      n_results++;
      if (rsp_ch.status == STATUS_FULL) n_full_seen++;
      if (rsp_ch.status == STATUS_BAD_REL) n_bad_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: slot %0d status %0d",
                   $realtime, rsp_ch.assigned_slot, rsp_ch.status);
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp_ch.assigned_slot !== exp_r.slot)
          report_mismatch("assigned_slot", 64'(exp_r.slot), 64'(rsp_ch.assigned_slot));
        if (rsp_ch.status !== exp_r.status)
          report_mismatch("status", 64'(exp_r.status), 64'(rsp_ch.status));
      end
    end
  end

  // Result sink back-pressure
  always @(negedge clk) begin
    rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Send one request transaction; valid stays high after acceptance
  task automatic send_request(input logic rt, input logic [SLOT_W-1:0] idx);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= rt;
    req_ch.slot_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_seat(rt, idx));
    if (rt == REQ_TAKE) n_take++;
    else n_release++;
  endtask

  // Stop sending and wait for every expected result
  task automatic hold_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ROOM_SIZE_ADDR) room_shadow = data[ROOM_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain, write room_size and read it back
  task automatic set_room_size(input int value);
    logic [31:0] rd;
    hold_until_drained();
    apb_write(ROOM_SIZE_ADDR, 32'(value));
    apb_read(ROOM_SIZE_ADDR, rd);
    if (rd !== {25'd0, room_shadow})
      report_mismatch("room_size readback", 64'(room_shadow), 64'(rd));
    n_rooms++;
  endtask

  task automatic test_register_reset();
    logic [31:0] rd;
    apb_read(ROOM_SIZE_ADDR, rd);
    if (rd !== {25'd0, ROOM_SIZE_RST})
      report_mismatch("room_size reset", 64'(ROOM_SIZE_RST), 64'(rd));
  endtask

  // Placement rules on the full 64-slot row
  task automatic test_directed_allocation();
    send_request(REQ_TAKE, 6'd63);      // empty row gives slot 0
    send_request(REQ_TAKE, 6'd0);       // right end
    send_request(REQ_TAKE, 6'd0);       // interior midpoint
    send_request(REQ_TAKE, 6'd0);       // larger half wins
    send_request(REQ_TAKE, 6'd0);       // wide left gap wins
    send_request(REQ_RELEASE, 6'd0);
    send_request(REQ_RELEASE, 6'd0);    // already free
    send_request(REQ_TAKE, 6'd21);      // left end wins
    send_request(REQ_RELEASE, 6'd63);
    send_request(REQ_RELEASE, 6'd62);   // never taken
  endtask

  // Room size clamping, full row and out-of-range release
  task automatic test_room_limits();
    set_room_size(1);
    send_request(REQ_TAKE, 6'd0);
    send_request(REQ_TAKE, 6'd0);       // row full
    send_request(REQ_RELEASE, 6'd1);    // beyond the room
    set_room_size(0);                   // acts as one slot
    send_request(REQ_TAKE, 6'd0);
    send_request(REQ_RELEASE, 6'd0);
    set_room_size(127);                 // acts as the full row
    send_request(REQ_TAKE, 6'd0);
    send_request(REQ_TAKE, 6'd0);
  endtask

  // Slots above a shrunk room are hidden, then seen again
  task automatic test_room_shrink();
    set_room_size(8);
    send_request(REQ_TAKE, 6'd0);
    send_request(REQ_TAKE, 6'd0);
    send_request(REQ_RELEASE, 6'd31);   // occupied but outside the room
    set_room_size(64);
    send_request(REQ_RELEASE, 6'd31);
    send_request(REQ_TAKE, 6'd0);
  endtask

  // One random phase at a given room size
  task automatic run_traffic_phase(input int room, input int items, input int take_pct,
                                   input bit quiet, input bit pause_mid);
    int n, cnt;
    int taken_list [$];
    logic rt;
    logic [SLOT_W-1:0] idx;
    set_room_size(room);
    calm = quiet;
    for (int k = 0; k < items; k++) begin
      n = room_slots();
      idx = SLOT_W'($urandom_range(0, SLOTS - 1));
      if ($urandom_range(0, 99) < take_pct) begin
        rt = REQ_TAKE;
      end else begin
        rt = REQ_RELEASE;
        taken_list.delete();
        for (int i = 0; i < n; i++) if (seat_taken[i]) taken_list.push_back(i);
        cnt = taken_list.size();
        // mostly valid releases, some noise
        if (cnt > 0 && $urandom_range(0, 99) < 80)
          idx = SLOT_W'(taken_list[$urandom_range(0, cnt - 1)]);
        else if ($urandom_range(0, 1) == 0)
          idx = SLOT_W'($urandom_range(0, n - 1));
      end
      send_request(rt, idx);
      if (pause_mid && k == items / 2) hold_until_drained();
    end
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int rooms [14] = '{1, 0, 2, 3, 5, 8, 13, 64, 127, 100, 17, 32, 7, 64};
    int pcts  [14] = '{60, 50, 70, 55, 65, 75, 60, 70, 45, 80, 55, 65, 50, 35};
    for (int p = 0; p < 14; p++)
      run_traffic_phase(rooms[p], 95, pcts[p], p == 7, p == 4);
  endtask

  initial begin
    int waited;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_TAKE;
    req_ch.slot_index = '0;
    rsp_ch.ready      = 1'b0;
    room_shadow       = ROOM_SIZE_RST;
    calm              = 1'b0;
    errors            = 0;
    mismatches        = 0;
    cycle_count       = 0;
    n_take            = 0;
    n_release         = 0;
    n_full_seen       = 0;
    n_bad_seen        = 0;
    n_results         = 0;
    n_rooms           = 0;
    foreach (seat_taken[i]) seat_taken[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_reset();
    test_directed_allocation();
    test_room_limits();
    test_room_shrink();
    test_random_traffic();

    // Final drain with a bound, then let the block settle
    @(negedge clk);
    req_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("Checked %0d results from %0d takes and %0d releases over %0d room settings",
             n_results, n_take, n_release, n_rooms);
    $display("Row-full results: %0d, rejected releases: %0d, mismatches: %0d",
             n_full_seen, n_bad_seen, mismatches);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/msa_pkg.sv
design/msa_if.sv
design/msa_ram.sv
design/msa_ctrl.sv
design/msa_dp.sv
design/max_distance_seat_allocator.sv
design/msa_chk.sv
dv/tb_top.sv
